/* hdl/dal_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Device address accept list: shared package
// Sizes, operation and status codes and the transfer types used by every
// module of the accept list.
// ----------------------------------------------------------------------------
package dal_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int ADDR_BYTES  = 6;
    localparam int ADDR_W      = 8 * ADDR_BYTES;
    localparam int TYPE_W      = 8;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_QUERY  = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_PRESENT   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]        mode;
        logic [TYPE_W-1:0] address_type;
        logic [ADDR_W-1:0] device_address;
    } t_in_item;

    typedef struct packed {
        logic       found;
        logic [1:0] status;
    } t_out_item;

    typedef struct packed {
        logic [TYPE_W-1:0] address_type;
        logic [ADDR_W-1:0] device_address;
    } t_slot;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        t_slot            wr_data;
        logic [IDX_W-1:0] rd_idx;
    } t_ram_req;

endpackage
`default_nettype wire

/* hdl/dal_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Device address accept list: slot store
// Holds the address and type of every slot; one write and one registered
// read per cycle.
// ----------------------------------------------------------------------------
module dal_store (
    input  wire logic              i_clk,
    input  wire dal_pkg::t_ram_req i_req,
    output dal_pkg::t_slot         o_rd_data
);

    dal_pkg::t_slot r_mem [dal_pkg::MAX_ENTRIES];
    dal_pkg::t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_idx] <= i_req.wr_data;
        end
        r_rd_data <= r_mem[i_req.rd_idx];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

/* hdl/dal_scan.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Device address accept list: slot compare unit
// Compares one stored slot against the key of the current transfer.
// ----------------------------------------------------------------------------
module dal_scan (
    input  wire dal_pkg::t_slot    i_slot,
    input  wire dal_pkg::t_in_item i_key,
    input  wire logic              i_slot_valid,
    output logic                   o_match
);

    always_comb begin
        o_match = i_slot_valid
               && (i_slot.address_type == i_key.address_type)
               && (i_slot.device_address == i_key.device_address);
    end

endmodule
`default_nettype wire

/* hdl/device_address_accept_list_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Device address accept list: top level
// A fixed set of device address and type pairs with add, remove, clear and
// query operations, searched one slot per cycle.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  request   start / busy         i_item   (mode, address_type, device_address)
//  result    o_result_valid       o_result (found, status)
//
// From acceptance to its result strobe an item passes the scan, tail and
// apply states: one slot is read from the store and compared each cycle, tail
// compares the last slot and apply makes the change. busy is high from the
// cycle after acceptance until the result is shown; a new item may be
// started in the cycle that carries the result. Reset empties the set at
// once. The result is held for one cycle only, as the receiver cannot stall.
// ----------------------------------------------------------------------------
module device_address_accept_list_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire dal_pkg::t_in_item i_item,
    output logic                   o_result_valid,
    output dal_pkg::t_out_item     o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_APPLY
    } t_state;

    t_state                         r_state, n_state;
    dal_pkg::t_in_item              r_key, n_key;
    logic [dal_pkg::IDX_W-1:0]      r_rd_idx, n_rd_idx;
    logic [dal_pkg::IDX_W-1:0]      r_cmp_idx, n_cmp_idx;
    logic                           r_cmp_vld, n_cmp_vld;
    logic                           r_hit, n_hit;
    logic [dal_pkg::IDX_W-1:0]      r_hit_idx, n_hit_idx;
    logic                           r_free_fnd, n_free_fnd;
    logic [dal_pkg::IDX_W-1:0]      r_free_idx, n_free_idx;
    logic [dal_pkg::MAX_ENTRIES-1:0] r_slot_valid, n_slot_valid;
    logic                           r_result_valid, n_result_valid;
    dal_pkg::t_out_item             r_result, n_result;

    dal_pkg::t_ram_req ram_req;
    dal_pkg::t_slot    rd_slot;
    logic              slot_match;
    logic              cmp_slot_valid;

    dal_store u_store (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_slot)
    );

    assign cmp_slot_valid = r_slot_valid[r_cmp_idx];

    dal_scan u_scan (
        .i_slot       (rd_slot),
        .i_key        (r_key),
        .i_slot_valid (cmp_slot_valid),
        .o_match      (slot_match)
    );

    always_comb begin
        n_state        = r_state;
        n_key          = r_key;
        n_rd_idx       = r_rd_idx;
        n_cmp_idx      = r_rd_idx;
        n_cmp_vld      = 1'b0;
        n_hit          = r_hit;
        n_hit_idx      = r_hit_idx;
        n_free_fnd     = r_free_fnd;
        n_free_idx     = r_free_idx;
        n_slot_valid   = r_slot_valid;
        n_result_valid = 1'b0;
        n_result       = r_result;

        ram_req.wr_en   = 1'b0;
        ram_req.wr_idx  = r_free_idx;
        ram_req.wr_data = '{address_type: r_key.address_type,
                            device_address: r_key.device_address};
        ram_req.rd_idx  = r_rd_idx;

        // The compare stage runs in the cycle after the read address is presented.
        if (r_cmp_vld) begin
            if (slot_match) begin
                n_hit     = 1'b1;
                n_hit_idx = r_cmp_idx;
            end
            if (!cmp_slot_valid && !r_free_fnd) begin
                n_free_fnd = 1'b1;
                n_free_idx = r_cmp_idx;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_key      = i_item;
                    n_rd_idx   = '0;
                    n_hit      = 1'b0;
                    n_free_fnd = 1'b0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                n_cmp_vld = 1'b1;
                if (r_rd_idx == dal_pkg::LAST_IDX) begin
                    n_state = S_TAIL;
                end else begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
            end
            S_TAIL: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                n_result.found  = r_hit;
                n_result.status = dal_pkg::ST_DONE;
                case (r_key.mode)
                    dal_pkg::MODE_ADD: begin
                        if (r_hit) begin
                            n_result.status = dal_pkg::ST_PRESENT;
                        end else if (r_free_fnd) begin
                            ram_req.wr_en            = 1'b1;
                            n_slot_valid[r_free_idx] = 1'b1;
                        end else begin
                            n_result.status = dal_pkg::ST_FULL;
                        end
                    end
                    dal_pkg::MODE_REMOVE: begin
                        if (r_hit) begin
                            n_slot_valid[r_hit_idx] = 1'b0;
                        end else begin
                            n_result.status = dal_pkg::ST_NOT_FOUND;
                        end
                    end
                    dal_pkg::MODE_CLEAR: begin
                        n_slot_valid = '0;
                    end
                    default: begin
                        if (!r_hit) begin
                            n_result.status = dal_pkg::ST_NOT_FOUND;
                        end
                    end
                endcase
                n_result_valid = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cmp_vld      <= 1'b0;
            r_slot_valid   <= '0;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_cmp_vld      <= n_cmp_vld;
            r_slot_valid   <= n_slot_valid;
            r_result_valid <= n_result_valid;
        end
        r_key      <= n_key;
        r_rd_idx   <= n_rd_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_free_fnd <= n_free_fnd;
        r_free_idx <= n_free_idx;
        r_result   <= n_result;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

endmodule
`default_nettype wire

/* verif/dal_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Device address accept list: result checker
// Watches the request and result channels of the accept list. It keeps its
// own copy of the slot table, works out the outcome of every accepted request
// and compares each result strobe against the oldest outcome still awaited.
// ----------------------------------------------------------------------------
module dal_checker
    import dal_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_start,
    input  wire logic      i_busy,
    input  wire t_in_item  i_item,
    input  wire logic      i_result_valid,
    input  wire t_out_item i_result,
    output int             o_mismatches,
    output int             o_outstanding,
    output int             o_full_reports,
    output int             o_hits
);

    bit                slot_used [MAX_ENTRIES];
    logic [ADDR_W-1:0] slot_addr [MAX_ENTRIES];
    logic [TYPE_W-1:0] slot_kind [MAX_ENTRIES];

    t_out_item outcome_q [$];

    initial begin
        o_mismatches   = 0;
        o_outstanding  = 0;
        o_full_reports = 0;
        o_hits         = 0;
        foreach (slot_used[k]) begin
            slot_used[k] = 1'b0;
        end
    end

    // Applies one list operation to the shadow table and returns its outcome.
    function automatic t_out_item apply_list_op(input t_in_item req);
        t_out_item res;
        int        hit_idx;
        int        free_idx;
        hit_idx  = -1;
        free_idx = -1;
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            if (hit_idx < 0 && slot_used[k] && slot_kind[k] == req.address_type
                && slot_addr[k] == req.device_address) begin
                hit_idx = k;
            end
            if (free_idx < 0 && !slot_used[k]) begin
                free_idx = k;
            end
        end
        res.found  = (hit_idx >= 0);
        res.status = ST_DONE;
        case (req.mode)
            MODE_ADD: begin
                if (hit_idx >= 0) begin
                    res.status = ST_PRESENT;
                end else if (free_idx < 0) begin
                    res.status = ST_FULL;
                end else begin
                    slot_used[free_idx] = 1'b1;
                    slot_addr[free_idx] = req.device_address;
                    slot_kind[free_idx] = req.address_type;
                end
            end
            MODE_REMOVE: begin
                if (hit_idx >= 0) begin
                    slot_used[hit_idx] = 1'b0;
                end else begin
                    res.status = ST_NOT_FOUND;
                end
            end
            MODE_CLEAR: begin
                foreach (slot_used[k]) begin
                    slot_used[k] = 1'b0;
                end
            end
            default: begin
                if (hit_idx < 0) begin
                    res.status = ST_NOT_FOUND;
                end
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (i_rst_n) begin
            if (i_result_valid) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual found %b status %0d",
                             $time, i_result.found, i_result.status);
                    o_mismatches++;
                end else begin
                    want = outcome_q.pop_front();
                    if (want.status == ST_FULL) begin
                        o_full_reports++;
                    end
                    if (want.found) begin
                        o_hits++;
                    end
                    if (i_result.found !== want.found) begin
                        $display("%0t: found mismatch: expected %b, actual %b",
                                 $time, want.found, i_result.found);
                        o_mismatches++;
                    end
                    if (i_result.status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, i_result.status);
                        o_mismatches++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                outcome_q.push_back(apply_list_op(i_item));
            end
        end
        o_outstanding = outcome_q.size();
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Device address accept list: testbench top
// Drives add, remove, clear and query requests into the accept list, first a
// directed sequence over the corner cases and then random traffic drawn
// mostly from a small pool of pairs, in bursts with random gaps. Checking is
// left to the checker module; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import dal_pkg::*;

    localparam int ITEM_TARGET    = 1100;
    localparam int POOL_SIZE      = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 3 * MAX_ENTRIES;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_result_valid;
    t_out_item o_result;

    int mismatches;
    int outstanding;
    int full_reports;
    int hits;
    int mode_count [4];
    int quiet_cycles = 0;

    t_slot pool [POOL_SIZE];

    device_address_accept_list_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    dal_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_item         (i_item),
        .i_result_valid (o_result_valid),
        .i_result       (o_result),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding),
        .o_full_reports (full_reports),
        .o_hits         (hits)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Ends the run if neither channel completes a transfer for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired after %0d idle cycles", $time, WATCHDOG_LIMIT);
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_in_item make_req(input logic [1:0] op,
                                          input logic [TYPE_W-1:0] kind,
                                          input logic [ADDR_W-1:0] addr);
        t_in_item req;
        req.mode           = op;
        req.address_type   = kind;
        req.device_address = addr;
        return req;
    endfunction

    // Mostly pool pairs so that hits, removals and a full table are common.
    function automatic t_in_item random_request(input int add_weight);
        t_in_item req;
        int       roll;
        int       pick;
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            req.mode = MODE_CLEAR;
        end else if (roll < 2 + add_weight) begin
            req.mode = MODE_ADD;
        end else if (roll < 2 + add_weight + (98 - add_weight) / 2) begin
            req.mode = MODE_REMOVE;
        end else begin
            req.mode = MODE_QUERY;
        end
        if ($urandom_range(0, 99) < 15) begin
            req.address_type   = TYPE_W'($urandom());
            req.device_address = ADDR_W'({$urandom(), $urandom()});
        end else begin
            pick               = $urandom_range(0, POOL_SIZE - 1);
            req.address_type   = pool[pick].address_type;
            req.device_address = pool[pick].device_address;
        end
        return req;
    endfunction

    task automatic send_request(input t_in_item req);
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= req;
        mode_count[req.mode]++;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int sent;
        int burst;
        int add_weight;
        int next_reweight;
        int roll;

        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        foreach (mode_count[m]) begin
            mode_count[m] = 0;
        end

        // Some pool pairs share an address or a type with others, so that
        // matching has to compare both fields in full.
        for (int p = 0; p < POOL_SIZE; p++) begin
            if (p >= 10 && p < 15) begin
                pool[p] = pool[p - 10];
                pool[p].address_type ^= 8'h01;
            end else if (p >= 15) begin
                pool[p] = pool[p - 10];
                pool[p].device_address ^= ADDR_W'(1) << $urandom_range(0, ADDR_W - 1);
            end else begin
                pool[p].address_type   = TYPE_W'($urandom());
                pool[p].device_address = ADDR_W'({$urandom(), $urandom()});
            end
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_request(make_req(MODE_QUERY, '0, '0));
        send_request(make_req(MODE_REMOVE, '0, '0));
        send_request(make_req(MODE_ADD, '0, '0));
        send_request(make_req(MODE_ADD, '0, '0));
        send_request(make_req(MODE_ADD, '1, '1));
        send_request(make_req(MODE_QUERY, 8'hFE, '1));
        send_request(make_req(MODE_QUERY, '1, '1));
        send_request(make_req(MODE_REMOVE, '1, '1));
        send_request(make_req(MODE_CLEAR, '0, '0));
        // Fill every slot, then one more add must report a full table.
        for (int n = 0; n <= MAX_ENTRIES; n++) begin
            send_request(make_req(MODE_ADD, pool[n].address_type, pool[n].device_address));
        end
        send_request(make_req(MODE_QUERY, pool[3].address_type, pool[3].device_address));
        send_request(make_req(MODE_CLEAR, 8'hA5, '1));
        wait_for_results();

        sent          = 0;
        next_reweight = 0;
        add_weight    = 40;
        while (sent < ITEM_TARGET) begin
            // Every 50 items, pick a filling or a draining phase of the table at random.
            if (sent >= next_reweight) begin
                add_weight    = $urandom_range(0, 1) ? 60 : 25;
                next_reweight = next_reweight + 50;
            end
            burst = $urandom_range(1, 16);
            for (int b = 0; b < burst && sent < ITEM_TARGET; b++) begin
                send_request(random_request(add_weight));
                sent++;
            end
            roll = $urandom_range(0, 9);
            if (roll == 0) begin
                wait_for_results();
            end else if (roll > 3) begin
                pause_sender($urandom_range(0, 30));
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Run covered %0d adds, %0d removes, %0d clears and %0d queries.",
                 mode_count[MODE_ADD], mode_count[MODE_REMOVE],
                 mode_count[MODE_CLEAR], mode_count[MODE_QUERY]);
        $display("%0d results reported a stored pair and %0d adds met a full table.",
                 hits, full_reports);
        if (mismatches == 0 && outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
